// ===== rtl/core/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
// depends on nothing; every other file but ffha_ram imports it

package ffha_pkg;

    localparam int REQ_W = 16;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_READ_CUR,
        DP_READ_BLK,
        DP_CAP_BLK,
        DP_EVAL,
        DP_ADV,
        DP_SPLIT_REST,
        DP_SPLIT_CUR,
        DP_LINK_REST,
        DP_LINK_NEXT,
        DP_REL_SETN,
        DP_REL_LINK,
        DP_MERGE_NEXT,
        DP_MERGE_PREV,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_ALLOC,
        RES_REL
    } res_kind_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_A_CHK,
        ST_A_EVAL,
        ST_A_SPL1,
        ST_A_SPL2,
        ST_A_LINK,
        ST_A_TAKE,
        ST_R_BLK,
        ST_R_CHK,
        ST_R_STOP,
        ST_R_ADV,
        ST_R_SETN,
        ST_R_LINK,
        ST_R_MNX,
        ST_R_MPV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t    op;
        res_kind_t res_kind;
    } ffha_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic zero_req;
        logic rel_skip;
        logic cur_null;
        logic cur_lt_blk;
        logic steps_over;
        logic steps_lim;
        logic fits;
        logic split_ok;
        logic adj_next;
        logic adj_prev;
    } ffha_stat_t;

endpackage

// ===== rtl/core/ffha_if.sv =====
// request and response channels of the allocator
// depends on ffha_pkg

interface ffha_req_if
    import ffha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [REQ_W-1:0] req_bytes;
    logic [REQ_W-1:0] release_offset;

    modport source (output valid, output req_type, output req_bytes,
                    output release_offset, input ready);
    modport sink   (input valid, input req_type, input req_bytes,
                    input release_offset, output ready);
endinterface

interface ffha_rsp_if
    import ffha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] data_offset;
    logic             ok;

    modport source (output valid, output data_offset, output ok, input ready);
    modport sink   (input valid, input data_offset, input ok, output ready);
endinterface

// ===== rtl/core/ffha_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module ffha_ram #(
    parameter int W = 16,
    parameter int D = 4096
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/ffha_datapath.sv =====
// header stores, list walk registers and result register of the allocator
// depends on ffha_pkg and ffha_ram

module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES    = 65536,
    parameter int GRANULE_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ffha_cmd_t        cmd,
    output ffha_stat_t       stat,
    input  logic             req_type,
    input  logic [REQ_W-1:0] req_bytes,
    input  logic [REQ_W-1:0] release_offset,
    output logic [REQ_W-1:0] data_offset,
    output logic             ok
);
    localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
    localparam int GIW   = $clog2(NGRAN);
    localparam int GW    = GIW + 1;
    localparam int SW    = $clog2(HEAP_BYTES);
    localparam int GSH   = $clog2(GRANULE_BYTES);
    localparam int NW    = REQ_W + 1;
    localparam int CW    = (SW > NW ? SW : NW) + 2;

    localparam logic [GW-1:0] NULL_G = GW'(NGRAN);
    localparam logic [CW-1:0] HDR_C  = CW'(GRANULE_BYTES);
    localparam logic [CW-1:0] NG_C   = CW'(NGRAN);
    localparam logic [CW-1:0] MAX_C  = CW'(HEAP_BYTES - GRANULE_BYTES);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    logic             type_reg, type_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [REQ_W-1:0] roff_reg, roff_next;
    logic [GW-1:0]    cur_reg, cur_next;
    logic [GW-1:0]    prev_reg, prev_next;
    logic [GW-1:0]    steps_reg, steps_next;
    logic [GW-1:0]    head_reg, head_next;
    logic [SW-1:0]    cur_sz_reg, cur_sz_next;
    logic [GW-1:0]    cur_nx_reg, cur_nx_next;
    logic [SW-1:0]    prev_sz_reg, prev_sz_next;
    logic [SW-1:0]    bsz_reg, bsz_next;
    logic [GW-1:0]    bnext_reg, bnext_next;
    logic [REQ_W-1:0] off_reg, off_next;
    logic             ok_reg, ok_next;

    logic           size_we, nx_we;
    logic [GIW-1:0] size_wa, nx_wa, rd_addr;
    logic [SW-1:0]  size_wd, rd_size;
    logic [GW-1:0]  nx_wd, rd_nx;

    logic [CW-1:0]  need_w, rest_w, roff_q, blk_w, merge_n_w, merge_p_w;
    logic [CW-1:0]  cur_b, prev_b, blk_b;
    logic [GIW-1:0] cur_idx, prev_idx, blk_idx, rest_idx;
    logic [GW-1:0]  curc;
    logic [SW-1:0]  merge_n, merge_p;
    logic           prev_null;
    logic           link_en;
    logic [GW-1:0]  link_node;

    ffha_ram #(.W(SW), .D(NGRAN)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_wa),
        .wdata (size_wd),
        .raddr (rd_addr),
        .rdata (rd_size)
    );

    ffha_ram #(.W(GW), .D(NGRAN)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_wa),
        .wdata (nx_wd),
        .raddr (rd_addr),
        .rdata (rd_nx)
    );

    assign need_w    = ((CW'(req_bytes) + HDR_C - ONE_C) >> GSH) << GSH;
    assign cur_idx   = cur_reg[GIW-1:0];
    assign prev_idx  = prev_reg[GIW-1:0];
    assign roff_q    = CW'(roff_reg) >> GSH;
    assign blk_w     = roff_q - ONE_C;
    assign blk_idx   = blk_w[GIW-1:0];
    assign rest_w    = CW'(cur_reg) + ONE_C + (CW'(need_reg) >> GSH);
    assign rest_idx  = rest_w[GIW-1:0];
    assign prev_null = prev_reg >= NULL_G;
    assign curc      = (cur_reg >= NULL_G) ? NULL_G : cur_reg;
    assign cur_b     = CW'(cur_reg) << GSH;
    assign prev_b    = CW'(prev_reg) << GSH;
    assign blk_b     = CW'(blk_idx) << GSH;
    assign merge_n_w = CW'(bsz_reg) + HDR_C + CW'(cur_sz_reg);
    assign merge_p_w = CW'(prev_sz_reg) + HDR_C + CW'(bsz_reg);
    assign merge_n   = (merge_n_w > MAX_C) ? SW'(MAX_C) : merge_n_w[SW-1:0];
    assign merge_p   = (merge_p_w > MAX_C) ? SW'(MAX_C) : merge_p_w[SW-1:0];

    always_comb
    begin
        stat.is_alloc   = !type_reg;
        stat.zero_req   = need_reg == '0;
        stat.rel_skip   = roff_reg == '0 || roff_reg[GSH-1:0] != '0 || roff_q > NG_C;
        stat.cur_null   = cur_reg >= NULL_G;
        stat.cur_lt_blk = cur_reg < GW'(blk_idx);
        stat.steps_over = steps_reg > NULL_G;
        stat.steps_lim  = steps_reg >= NULL_G;
        stat.fits       = CW'(rd_size) >= CW'(need_reg);
        stat.split_ok   = CW'(rd_size) >= CW'(need_reg) + HDR_C && rest_w < NG_C;
        stat.adj_next   = cur_reg < NULL_G && blk_b + HDR_C + CW'(bsz_reg) == cur_b;
        stat.adj_prev   = !prev_null && prev_b + HDR_C + CW'(prev_sz_reg) == blk_b;
    end

    always_comb
    begin
        type_next    = type_reg;
        need_next    = need_reg;
        roff_next    = roff_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        steps_next   = steps_reg;
        head_next    = head_reg;
        cur_sz_next  = cur_sz_reg;
        cur_nx_next  = cur_nx_reg;
        prev_sz_next = prev_sz_reg;
        bsz_next     = bsz_reg;
        bnext_next   = bnext_reg;
        off_next     = off_reg;
        ok_next      = ok_reg;
        size_we      = 1'b0;
        size_wa      = cur_idx;
        size_wd      = '0;
        nx_we        = 1'b0;
        nx_wa        = cur_idx;
        nx_wd        = '0;
        rd_addr      = cur_idx;
        link_en      = 1'b0;
        link_node    = '0;
        case (cmd.op)
            DP_INIT:
            begin
                size_we   = 1'b1;
                size_wa   = '0;
                size_wd   = SW'(MAX_C);
                nx_we     = 1'b1;
                nx_wa     = '0;
                nx_wd     = NULL_G;
                head_next = '0;
            end
            DP_LOAD:
            begin
                type_next  = req_type;
                need_next  = need_w[NW-1:0];
                roff_next  = release_offset;
                cur_next   = head_reg;
                prev_next  = NULL_G;
                steps_next = '0;
            end
            DP_READ_CUR:
            begin
                rd_addr = cur_idx;
            end
            DP_READ_BLK:
            begin
                rd_addr = blk_idx;
            end
            DP_CAP_BLK:
            begin
                bsz_next = rd_size;
            end
            DP_EVAL:
            begin
                cur_sz_next = rd_size;
                cur_nx_next = rd_nx;
            end
            DP_ADV:
            begin
                cur_sz_next  = rd_size;
                cur_nx_next  = rd_nx;
                prev_next    = cur_reg;
                prev_sz_next = rd_size;
                cur_next     = rd_nx;
                steps_next   = steps_reg + GW'(1);
            end
            DP_SPLIT_REST:
            begin
                size_we = 1'b1;
                size_wa = rest_idx;
                size_wd = SW'(CW'(cur_sz_reg) - CW'(need_reg) - HDR_C);
                nx_we   = 1'b1;
                nx_wa   = rest_idx;
                nx_wd   = cur_nx_reg;
            end
            DP_SPLIT_CUR:
            begin
                size_we = 1'b1;
                size_wa = cur_idx;
                size_wd = SW'(need_reg);
                nx_we   = 1'b1;
                nx_wa   = cur_idx;
                nx_wd   = GW'(rest_idx);
            end
            DP_LINK_REST:
            begin
                link_en   = 1'b1;
                link_node = GW'(rest_idx);
            end
            DP_LINK_NEXT:
            begin
                link_en   = 1'b1;
                link_node = cur_nx_reg;
            end
            DP_REL_SETN:
            begin
                nx_we      = 1'b1;
                nx_wa      = blk_idx;
                nx_wd      = curc;
                bnext_next = curc;
            end
            DP_REL_LINK:
            begin
                link_en   = 1'b1;
                link_node = GW'(blk_idx);
            end
            DP_MERGE_NEXT:
            begin
                size_we    = 1'b1;
                size_wa    = blk_idx;
                size_wd    = merge_n;
                nx_we      = 1'b1;
                nx_wa      = blk_idx;
                nx_wd      = cur_nx_reg;
                bsz_next   = merge_n;
                bnext_next = cur_nx_reg;
            end
            DP_MERGE_PREV:
            begin
                size_we = 1'b1;
                size_wa = prev_idx;
                size_wd = merge_p;
                nx_we   = 1'b1;
                nx_wa   = prev_idx;
                nx_wd   = bnext_reg;
            end
            DP_RESULT:
            begin
                case (cmd.res_kind)
                    RES_ALLOC:
                    begin
                        off_next = REQ_W'(cur_b + HDR_C);
                        ok_next  = 1'b1;
                    end
                    RES_REL:
                    begin
                        off_next = '0;
                        ok_next  = 1'b1;
                    end
                    default:
                    begin
                        off_next = '0;
                        ok_next  = 1'b0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        // link after prev, or move the list head
        if (link_en)
        begin
            if (prev_null)
            begin
                head_next = link_node;
            end
            else
            begin
                nx_we = 1'b1;
                nx_wa = prev_idx;
                nx_wd = link_node;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        need_reg    <= need_next;
        roff_reg    <= roff_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        steps_reg   <= steps_next;
        cur_sz_reg  <= cur_sz_next;
        cur_nx_reg  <= cur_nx_next;
        prev_sz_reg <= prev_sz_next;
        bsz_reg     <= bsz_next;
        bnext_reg   <= bnext_next;
        off_reg     <= off_next;
        ok_reg      <= ok_next;
    end

    assign data_offset = off_reg;
    assign ok          = ok_reg;
endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// control state machine of the allocator: sequences list walks and header updates
// depends on ffha_pkg

module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ffha_stat_t stat,
    output ffha_cmd_t  cmd,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready
);
    ctrl_state_t state_reg, state_next;
    res_kind_t   kind_reg, kind_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            kind_reg      <= RES_FAIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = DP_NOP;
        cmd.res_kind   = kind_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.op     = DP_INIT;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_alloc)
                begin
                    if (stat.zero_req)
                    begin
                        kind_next  = RES_FAIL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_A_CHK;
                    end
                end
                else if (stat.rel_skip)
                begin
                    kind_next  = RES_REL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_READ_BLK;
                    state_next = ST_R_BLK;
                end
            end
            ST_A_CHK:
            begin
                if (stat.cur_null || stat.steps_over)
                begin
                    kind_next  = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_READ_CUR;
                    state_next = ST_A_EVAL;
                end
            end
            ST_A_EVAL:
            begin
                if (!stat.fits)
                begin
                    cmd.op     = DP_ADV;
                    state_next = ST_A_CHK;
                end
                else
                begin
                    cmd.op     = DP_EVAL;
                    state_next = stat.split_ok ? ST_A_SPL1 : ST_A_TAKE;
                end
            end
            ST_A_SPL1:
            begin
                cmd.op     = DP_SPLIT_REST;
                state_next = ST_A_SPL2;
            end
            ST_A_SPL2:
            begin
                cmd.op     = DP_SPLIT_CUR;
                state_next = ST_A_LINK;
            end
            ST_A_LINK:
            begin
                cmd.op     = DP_LINK_REST;
                kind_next  = RES_ALLOC;
                state_next = ST_DONE;
            end
            ST_A_TAKE:
            begin
                cmd.op     = DP_LINK_NEXT;
                kind_next  = RES_ALLOC;
                state_next = ST_DONE;
            end
            ST_R_BLK:
            begin
                cmd.op     = DP_CAP_BLK;
                state_next = ST_R_CHK;
            end
            ST_R_CHK:
            begin
                if (stat.cur_null)
                begin
                    state_next = ST_R_SETN;
                end
                else if (!stat.cur_lt_blk)
                begin
                    cmd.op     = DP_READ_CUR;
                    state_next = ST_R_STOP;
                end
                else if (stat.steps_lim)
                begin
                    kind_next  = RES_REL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_READ_CUR;
                    state_next = ST_R_ADV;
                end
            end
            ST_R_STOP:
            begin
                cmd.op     = DP_EVAL;
                state_next = ST_R_SETN;
            end
            ST_R_ADV:
            begin
                cmd.op     = DP_ADV;
                state_next = ST_R_CHK;
            end
            ST_R_SETN:
            begin
                cmd.op     = DP_REL_SETN;
                state_next = ST_R_LINK;
            end
            ST_R_LINK:
            begin
                cmd.op     = DP_REL_LINK;
                state_next = ST_R_MNX;
            end
            ST_R_MNX:
            begin
                if (stat.adj_next)
                begin
                    cmd.op = DP_MERGE_NEXT;
                end
                state_next = ST_R_MPV;
            end
            ST_R_MPV:
            begin
                if (stat.adj_prev)
                begin
                    cmd.op = DP_MERGE_PREV;
                end
                kind_next  = RES_REL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first-fit heap allocator: one granule header per block, address-ordered free list
// alloc walks past free blocks too small and splits the first that fits when the rest can
// hold a header; release walks past free blocks below, links the block in and merges it
// with adjacent free blocks; zero, null or malformed requests skip the walk; one request
// at a time; reset: the init state writes the single whole-heap free block, then ready
// depends on ffha_pkg, ffha_if, ffha_ram, ffha_datapath, ffha_ctrl

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES    = 65536,
    parameter int GRANULE_BYTES = 16
) (
    input logic        clk,
    input logic        rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);
    ffha_cmd_t  cmd;
    ffha_stat_t stat;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .cmd       (cmd),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready)
    );

    ffha_datapath #(
        .HEAP_BYTES    (HEAP_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req.req_type),
        .req_bytes      (req.req_bytes),
        .release_offset (req.release_offset),
        .data_offset    (rsp.data_offset),
        .ok             (rsp.ok)
    );
endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
// self-checking testbench for first_fit_heap_allocator: alloc and release beats are
// predicted by a heap model in a small scoreboard class and every response is compared
// depends on ffha_pkg, ffha_if and the allocator rtl
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

    import ffha_pkg::*;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;
    localparam int   IDLE_PCT    = 35;

    typedef struct packed {
        logic [REQ_W-1:0] data_offset;
        logic             ok;
    } heap_rsp_t;

    class heap_scoreboard;
        localparam int unsigned GRAN     = 16;
        localparam int unsigned NGRAN    = 4096;
        localparam int unsigned NULL_G   = NGRAN;
        localparam int unsigned MAX_SIZE = 65536 - GRAN;

        int unsigned size_mem [NGRAN];
        int unsigned next_mem [NGRAN];
        int unsigned head;
        heap_rsp_t   expected_q [$];
        int          errors;
        int          checked;

        function void power_up();
            for (int g = 0; g < NGRAN; g++)
            begin
                size_mem[g] = '0;
                next_mem[g] = '0;
            end
            size_mem[0] = MAX_SIZE;
            next_mem[0] = NULL_G;
            head        = '0;
            expected_q.delete();
            errors      = 0;
            checked     = 0;
        endfunction

        function void relink(int unsigned prev, int unsigned node);
            if (prev == NULL_G)
                head = node;
            else
                next_mem[prev] = node;
        endfunction

        function int unsigned clamp_size(int unsigned v);
            return (v > MAX_SIZE) ? MAX_SIZE : v;
        endfunction

        function heap_rsp_t carve(int unsigned n);
            heap_rsp_t   r;
            int unsigned need;
            int unsigned prev;
            int unsigned cur;
            int unsigned steps;
            int unsigned sz;
            int unsigned rest;
            r.data_offset = '0;
            r.ok          = 1'b0;
            if (n == 0)
                return r;
            need  = ((n + GRAN - 1) / GRAN) * GRAN;
            prev  = NULL_G;
            cur   = head;
            steps = 0;
            while (cur < NGRAN && steps <= NGRAN)
            begin
                sz = size_mem[cur];
                if (sz >= need)
                begin
                    rest = cur + 1 + need / GRAN;
                    if (sz >= need + GRAN && rest < NGRAN)
                    begin
                        size_mem[rest] = sz - need - GRAN;
                        next_mem[rest] = next_mem[cur];
                        size_mem[cur]  = need;
                        next_mem[cur]  = rest;
                        relink(prev, rest);
                    end
                    else
                    begin
                        relink(prev, next_mem[cur]);
                    end
                    r.ok          = 1'b1;
                    r.data_offset = 16'(cur * GRAN + GRAN);
                    return r;
                end
                prev  = cur;
                cur   = next_mem[cur];
                steps = steps + 1;
            end
            return r;
        endfunction

        function void give_back(int unsigned off);
            int unsigned blk;
            int unsigned prev;
            int unsigned cur;
            int unsigned steps;
            int unsigned sz;
            if (off == 0 || off % GRAN != 0)
                return;
            blk = off / GRAN - 1;
            if (blk >= NGRAN)
                return;
            sz    = size_mem[blk];
            prev  = NULL_G;
            cur   = head;
            steps = 0;
            while (cur < NGRAN && cur < blk)
            begin
                if (steps >= NGRAN)
                    return;
                prev  = cur;
                cur   = next_mem[cur];
                steps = steps + 1;
            end
            if (cur > NULL_G)
                cur = NULL_G;
            next_mem[blk] = cur;
            relink(prev, blk);
            if (cur < NGRAN && blk * GRAN + GRAN + sz == cur * GRAN)
            begin
                size_mem[blk] = clamp_size(sz + GRAN + size_mem[cur]);
                next_mem[blk] = next_mem[cur];
            end
            if (prev < NGRAN && prev * GRAN + GRAN + size_mem[prev] == blk * GRAN)
            begin
                size_mem[prev] = clamp_size(size_mem[prev] + GRAN + size_mem[blk]);
                next_mem[prev] = next_mem[blk];
            end
        endfunction

        function heap_rsp_t note_request(logic kind, logic [15:0] bytes, logic [15:0] off);
            heap_rsp_t r;
            if (kind == REQ_ALLOC)
            begin
                r = carve(32'(bytes));
            end
            else
            begin
                give_back(32'(off));
                r.data_offset = '0;
                r.ok          = 1'b1;
            end
            expected_q.push_back(r);
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors = errors + 1;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_response(logic [15:0] data_offset, logic ok);
            heap_rsp_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected response beat, offset %h ok %b",
                                 data_offset, ok));
            end
            else
            begin
                want    = expected_q.pop_front();
                checked = checked + 1;
                if (data_offset !== want.data_offset)
                    report($sformatf("data_offset %h, want %h", data_offset,
                                     want.data_offset));
                if (ok !== want.ok)
                    report($sformatf("ok %b, want %b (offset %h)", ok, want.ok,
                                     want.data_offset));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;

    ffha_req_if req_bus ();
    ffha_rsp_if rsp_bus ();

    first_fit_heap_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    heap_scoreboard sb;
    logic [15:0]    held [$];
    logic [15:0]    handed_out [$];
    int             n_alloc;
    int             n_granted;
    int             n_release;
    int             n_odd;

    always #5 clk = ~clk;

    function bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(1, 128));
        else if (r < 85)
            return 16'($urandom_range(129, 1024));
        else if (r < 95)
            return 16'($urandom_range(1025, 8192));
        else if (r < 99)
            return 16'($urandom_range(8193, 65535));
        return 16'd0;
    endfunction

    task send_beat(logic kind, logic [15:0] bytes, logic [15:0] off);
        heap_rsp_t got;
        @(negedge clk);
        while (take_break())
        begin
            req_bus.valid          <= 1'b0;
            req_bus.req_type       <= 1'($urandom_range(1));
            req_bus.req_bytes      <= 16'($urandom);
            req_bus.release_offset <= 16'($urandom);
            @(negedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.req_type       <= kind;
        req_bus.req_bytes      <= bytes;
        req_bus.release_offset <= off;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        got = sb.note_request(kind, bytes, off);
        if (kind == REQ_ALLOC)
        begin
            n_alloc = n_alloc + 1;
            if (got.ok && got.data_offset != 0)
            begin
                n_granted = n_granted + 1;
                held.push_back(got.data_offset);
                handed_out.push_back(got.data_offset);
            end
        end
        else
        begin
            n_release = n_release + 1;
        end
    endtask

    task alloc_beat(logic [15:0] bytes);
        send_beat(REQ_ALLOC, bytes, 16'($urandom));
    endtask

    task release_beat(logic [15:0] off);
        for (int k = 0; k < held.size(); k++)
        begin
            if (held[k] == off)
            begin
                held.delete(k);
                break;
            end
        end
        send_beat(REQ_RELEASE, 16'($urandom), off);
    endtask

    task release_held();
        send_beat(REQ_RELEASE, 16'($urandom), 16'd0);
    endtask

    task release_some_held();
        int idx;
        idx = int'($urandom_range(held.size() - 1));
        release_beat(held[idx]);
    endtask

    task odd_release();
        logic [15:0] off;
        if ($urandom_range(3) == 0)
            off = 16'd0;
        else
            off = {12'($urandom), 4'($urandom_range(1, 15))};
        n_odd = n_odd + 1;
        send_beat(REQ_RELEASE, 16'($urandom), off);
    endtask

    always @(negedge clk)
        rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.data_offset, rsp_bus.ok);
    end

    initial
    begin
        #(25_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int spin;
        int r;
        sb = new();
        sb.power_up();
        n_alloc                = 0;
        n_granted              = 0;
        n_release              = 0;
        n_odd                  = 0;
        calm                   = 1'b0;
        rst_n                  = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_ALLOC;
        req_bus.req_bytes      = '0;
        req_bus.release_offset = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // zero size, oversize, whole heap and exhausted heap
        alloc_beat(16'd0);
        alloc_beat(16'd65535);
        alloc_beat(16'd65520);
        alloc_beat(16'd1);
        release_held();
        release_beat(16'd16);
        // small splits, malformed releases, coalescing on both sides
        alloc_beat(16'd1);
        alloc_beat(16'd17);
        alloc_beat(16'd100);
        alloc_beat(16'd16);
        release_beat(16'd8);
        release_beat(16'd65535);
        release_beat(16'hFFF8);
        release_beat(16'd48);
        release_beat(16'd224);
        release_beat(16'd16);
        release_beat(16'd96);
        // split leaving an empty remainder, then an exact fit without split
        alloc_beat(16'd65504);
        alloc_beat(16'd1);
        release_beat(16'd16);
        alloc_beat(16'd65505);
        alloc_beat(16'd16);
        release_beat(16'd16);

        for (int i = 0; i < 640; i++)
        begin
            calm = (i >= 250 && i < 400);
            r    = $urandom_range(99);
            if (r < 6)
                odd_release();
            else if (held.size() == 0 ||
                     $urandom_range(99) < ((held.size() > 40) ? 35 : 60))
                alloc_beat(pick_size());
            else
                release_some_held();
        end
        calm = 1'b0;

        // drain back to one free block
        while (held.size() != 0)
            release_some_held();
        alloc_beat(16'd65520);
        release_beat(16'd16);

        // double releases leave the list corrupt; the walks must stay bounded
        for (int j = 0; j < 12; j++)
        begin
            if (j % 3 == 0)
                release_beat(handed_out[$urandom_range(handed_out.size() - 1)]);
            else
                alloc_beat(pick_size());
        end

        @(negedge clk);
        req_bus.valid <= 1'b0;

        spin = 0;
        while (sb.pending() != 0 && spin < 200000)
        begin
            @(posedge clk);
            spin = spin + 1;
        end
        repeat (64) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.pending()));

        $display("run: %0d alloc beats (%0d granted), %0d release beats (%0d null/malformed)",
                 n_alloc, n_granted, n_release, n_odd);
        $display("run: %0d responses checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== first_fit_heap_allocator.f =====
rtl/core/ffha_pkg.sv
rtl/core/ffha_if.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_datapath.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
